// File: src/ctpr_pkg.sv
// ---------------------------------------------------------------------------
// ctpr_pkg: shared constants, types and tables
// Fixed-point formats, the CORDIC arctangent table and the control bundle
// that travels along the cell chain.
// ---------------------------------------------------------------------------
package ctpr_pkg;

    localparam int COORD_WIDTH_DEF    = 16;
    localparam int ROTATION_STEPS_DEF = 16;

    // CORDIC: coordinates scaled by 2^16, angle in degrees * 2^16
    localparam int FRAC_SHIFT     = 16;
    localparam int TABLE_LEN      = 24;
    localparam int Z_W            = 27;
    localparam int ZR_W           = Z_W - 8;
    localparam int HALF_TURN_DEG  = 180;
    localparam int Z_HALF_TURN    = HALF_TURN_DEG * 65536;
    localparam int ANGLE_LIMIT    = HALF_TURN_DEG * 256;
    localparam int ANGLE_W        = 17;
    localparam int REL_W          = 18;

    // radius: floor(sqrt(sum << 16)), one root bit per cell
    localparam int SUM_KEEP       = 33;
    localparam int SQRT_PRE_SHIFT = 16;
    localparam int SQ_OP_W        = 1 + SUM_KEEP + SQRT_PRE_SHIFT;
    localparam int SQRT_STEPS     = SQ_OP_W / 2;
    localparam int ROOT_W         = SQRT_STEPS;
    localparam int REM_W          = ROOT_W + 3;
    localparam int RADIUS_W       = 24;

    typedef struct packed {
        logic valid;
        logic origin;
        logic sat;
        logic last;
    } t_ctl;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = Z_W'(2949120);
            5'd1:    v = Z_W'(1740967);
            5'd2:    v = Z_W'(919879);
            5'd3:    v = Z_W'(466945);
            5'd4:    v = Z_W'(234379);
            5'd5:    v = Z_W'(117304);
            5'd6:    v = Z_W'(58666);
            5'd7:    v = Z_W'(29335);
            5'd8:    v = Z_W'(14668);
            5'd9:    v = Z_W'(7334);
            5'd10:   v = Z_W'(3667);
            5'd11:   v = Z_W'(1833);
            5'd12:   v = Z_W'(917);
            5'd13:   v = Z_W'(458);
            5'd14:   v = Z_W'(229);
            5'd15:   v = Z_W'(115);
            5'd16:   v = Z_W'(57);
            5'd17:   v = Z_W'(29);
            5'd18:   v = Z_W'(14);
            5'd19:   v = Z_W'(7);
            5'd20:   v = Z_W'(4);
            5'd21:   v = Z_W'(2);
            5'd22:   v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/ctpr_prep.sv
// ---------------------------------------------------------------------------
// ctpr_prep: input conditioning
// Stage one folds the left half-plane onto the right, seeds the angle and
// squares the magnitudes; stage two sums the squares into the root operand.
// ---------------------------------------------------------------------------
module ctpr_prep #(
    parameter int COORD_WIDTH = ctpr_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [COORD_WIDTH-1:0]      i_x_coord,
    input  logic signed [COORD_WIDTH-1:0]      i_y_coord,
    input  logic                               i_last_point,
    output ctpr_pkg::t_ctl                     o_ctl,
    output logic signed [COORD_WIDTH+17:0]     o_x,
    output logic signed [COORD_WIDTH+17:0]     o_y,
    output logic signed [ctpr_pkg::Z_W-1:0]    o_z,
    output logic [ctpr_pkg::SQ_OP_W-1:0]       o_op
);
    import ctpr_pkg::*;

    localparam int XW    = COORD_WIDTH + 18;
    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int SUM_W = (SQ_W + 1 > SUM_KEEP) ? SQ_W + 1 : SUM_KEEP;
    localparam logic signed [Z_W-1:0] Z_POS = Z_W'(Z_HALF_TURN);
    localparam logic signed [Z_W-1:0] Z_NEG = -Z_POS;
    localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(64'd1 << 32);

    logic                   x_neg;
    logic [COORD_WIDTH-1:0] ax;
    logic [COORD_WIDTH-1:0] ay;
    logic signed [XW-1:0]   xs;
    logic signed [XW-1:0]   ys;
    t_ctl                   n1_ctl;
    logic signed [XW-1:0]   n1_x;
    logic signed [XW-1:0]   n1_y;
    logic signed [Z_W-1:0]  n1_z;

    t_ctl                   r1_ctl;
    logic signed [XW-1:0]   r1_x;
    logic signed [XW-1:0]   r1_y;
    logic signed [Z_W-1:0]  r1_z;
    logic [SQ_W-1:0]        r1_sqx;
    logic [SQ_W-1:0]        r1_sqy;

    logic [SUM_W-1:0]       sum;
    t_ctl                   n2_ctl;
    logic [SQ_OP_W-1:0]     n2_op;

    t_ctl                   r2_ctl;
    logic signed [XW-1:0]   r2_x;
    logic signed [XW-1:0]   r2_y;
    logic signed [Z_W-1:0]  r2_z;
    logic [SQ_OP_W-1:0]     r2_op;

    always_comb begin
        x_neg = i_x_coord[COORD_WIDTH-1];
        ax = x_neg ? COORD_WIDTH'(~i_x_coord + 1'b1) : i_x_coord;
        ay = i_y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(~i_y_coord + 1'b1) : i_y_coord;
        xs = {{(XW-COORD_WIDTH-FRAC_SHIFT){i_x_coord[COORD_WIDTH-1]}}, i_x_coord,
              {FRAC_SHIFT{1'b0}}};
        ys = {{(XW-COORD_WIDTH-FRAC_SHIFT){i_y_coord[COORD_WIDTH-1]}}, i_y_coord,
              {FRAC_SHIFT{1'b0}}};
        // left half-plane: rotate by a half turn first
        n1_x = x_neg ? -xs : xs;
        n1_y = x_neg ? -ys : ys;
        if (!x_neg) begin
            n1_z = '0;
        end else if (!i_y_coord[COORD_WIDTH-1]) begin
            n1_z = Z_POS;
        end else begin
            n1_z = Z_NEG;
        end
        n1_ctl.valid  = i_valid;
        n1_ctl.origin = (i_x_coord == '0) && (i_y_coord == '0);
        n1_ctl.sat    = 1'b0;
        n1_ctl.last   = i_last_point;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
        end else if (i_en) begin
            r1_ctl <= n1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r1_z   <= n1_z;
            r1_sqx <= SQ_W'(ax) * SQ_W'(ax);
            r1_sqy <= SQ_W'(ay) * SQ_W'(ay);
        end
    end

    always_comb begin
        sum        = SUM_W'(r1_sqx) + SUM_W'(r1_sqy);
        n2_ctl     = r1_ctl;
        n2_ctl.sat = sum > SUM_LIMIT;
        n2_op      = {1'b0, sum[SUM_KEEP-1:0], {SQRT_PRE_SHIFT{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_ctl <= '0;
        end else if (i_en) begin
            r2_ctl <= n2_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_z  <= r1_z;
            r2_op <= n2_op;
        end
    end

    assign o_ctl = r2_ctl;
    assign o_x   = r2_x;
    assign o_y   = r2_y;
    assign o_z   = r2_z;
    assign o_op  = r2_op;

endmodule

// File: src/ctpr_cell.sv
// ---------------------------------------------------------------------------
// ctpr_cell: one link of the conversion chain
// Does one CORDIC vectoring rotation (when its step is in use) and one
// restoring square-root digit, then registers the lot for the next cell.
// ---------------------------------------------------------------------------
module ctpr_cell #(
    parameter int COORD_WIDTH    = ctpr_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STEPS = ctpr_pkg::ROTATION_STEPS_DEF,
    parameter int STEP           = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  ctpr_pkg::t_ctl                     i_ctl,
    input  logic signed [COORD_WIDTH+17:0]     i_x,
    input  logic signed [COORD_WIDTH+17:0]     i_y,
    input  logic signed [ctpr_pkg::Z_W-1:0]    i_z,
    input  logic [ctpr_pkg::SQ_OP_W-1:0]       i_op,
    input  logic [ctpr_pkg::REM_W-1:0]         i_rem,
    input  logic [ctpr_pkg::ROOT_W-1:0]        i_root,
    output ctpr_pkg::t_ctl                     o_ctl,
    output logic signed [COORD_WIDTH+17:0]     o_x,
    output logic signed [COORD_WIDTH+17:0]     o_y,
    output logic signed [ctpr_pkg::Z_W-1:0]    o_z,
    output logic [ctpr_pkg::SQ_OP_W-1:0]       o_op,
    output logic [ctpr_pkg::REM_W-1:0]         o_rem,
    output logic [ctpr_pkg::ROOT_W-1:0]        o_root
);
    import ctpr_pkg::*;

    localparam int XW      = COORD_WIDTH + 18;
    localparam int ROT_EFF = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam bit ROTATE  = STEP < ROT_EFF;
    localparam logic signed [Z_W-1:0] ATAN = atan_entry(5'(STEP));

    logic signed [XW-1:0]  dx;
    logic signed [XW-1:0]  dy;
    logic signed [XW-1:0]  n_x;
    logic signed [XW-1:0]  n_y;
    logic signed [Z_W-1:0] n_z;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  take;
    logic [REM_W-1:0]      n_rem;
    logic [ROOT_W-1:0]     n_root;
    logic [SQ_OP_W-1:0]    n_op;

    t_ctl                  r_ctl;
    logic signed [XW-1:0]  r_x;
    logic signed [XW-1:0]  r_y;
    logic signed [Z_W-1:0] r_z;
    logic [SQ_OP_W-1:0]    r_op;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        if (!ROTATE) begin
            n_x = i_x;
            n_y = i_y;
            n_z = i_z;
        end else if (i_y[XW-1]) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN;
        end
    end

    // one root bit: bring down two operand bits, try (root << 2) | 1
    always_comb begin
        rem_sh = {i_rem[REM_W-3:0], i_op[SQ_OP_W-1 -: 2]};
        trial  = REM_W'({i_root, 2'b01});
        take   = rem_sh >= trial;
        n_rem  = take ? rem_sh - trial : rem_sh;
        n_root = {i_root[ROOT_W-2:0], take};
        n_op   = {i_op[SQ_OP_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_op   <= n_op;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_op   = r_op;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// File: src/ctpr_post.sv
// ---------------------------------------------------------------------------
// ctpr_post: result stage
// Rounds and clamps the angle, forms the relative angle against the stored
// previous vertex, saturates the radius and holds the result register.
// ---------------------------------------------------------------------------
module ctpr_post (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ctpr_pkg::t_ctl                      i_ctl,
    input  logic signed [ctpr_pkg::Z_W-1:0]     i_z,
    input  logic [ctpr_pkg::ROOT_W-1:0]         i_root,
    input  logic                                i_out_ready,
    output logic                                o_en,
    output logic                                o_out_valid,
    output logic [ctpr_pkg::RADIUS_W-1:0]       o_radius,
    output logic signed [ctpr_pkg::REL_W-1:0]   o_rel_angle,
    output logic                                o_last_out
);
    import ctpr_pkg::*;

    localparam logic signed [Z_W-1:0]  Z_ROUND = Z_W'(1 << 7);
    localparam logic signed [ZR_W-1:0] LIM_P   = ZR_W'(ANGLE_LIMIT);
    localparam logic signed [ZR_W-1:0] LIM_N   = -LIM_P;

    logic signed [Z_W-1:0]     z_rnd;
    logic signed [ZR_W-1:0]    zr;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [REL_W-1:0]   rel;
    logic [RADIUS_W-1:0]       radius;
    logic                      en;

    logic                      r_valid;
    logic signed [ANGLE_W-1:0] r_prev;
    logic [RADIUS_W-1:0]       r_radius;
    logic signed [REL_W-1:0]   r_rel;
    logic                      r_last;

    always_comb begin
        z_rnd = i_z + Z_ROUND;
        zr    = z_rnd[Z_W-1:8];
        if (i_ctl.origin) begin
            ang = '0;
        end else if (zr > LIM_P) begin
            ang = LIM_P[ANGLE_W-1:0];
        end else if (zr < LIM_N) begin
            ang = LIM_N[ANGLE_W-1:0];
        end else begin
            ang = zr[ANGLE_W-1:0];
        end
        rel = {{(REL_W-ANGLE_W){ang[ANGLE_W-1]}}, ang}
            - {{(REL_W-ANGLE_W){r_prev[ANGLE_W-1]}}, r_prev};
        // root above 24 bits only when the sum already hit the limit
        radius = (i_ctl.sat || i_root[ROOT_W-1]) ? '1 : i_root[RADIUS_W-1:0];
        en     = !r_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
        end else if (en) begin
            r_valid <= i_ctl.valid;
            if (i_ctl.valid) begin
                r_prev <= i_ctl.last ? '0 : ang;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_ctl.valid) begin
            r_radius <= radius;
            r_rel    <= rel;
            r_last   <= i_ctl.last;
        end
    end

    assign o_en        = en;
    assign o_out_valid = r_valid;
    assign o_radius    = r_radius;
    assign o_rel_angle = r_rel;
    assign o_last_out  = r_last;

endmodule

// File: src/cartesian_to_polar_relative.sv
// ---------------------------------------------------------------------------
// cartesian_to_polar_relative: vertex to polar with relative angle
// Two prep stages, a chain of 25 cells (one root digit each, plus one
// CORDIC rotation in each cell whose step is in use), one result register.
// One item per cycle sustained; the chain stalls as a whole while a result
// waits. Reset empties the chain and clears the previous angle.
// ---------------------------------------------------------------------------
module cartesian_to_polar_relative #(
    parameter int COORD_WIDTH    = ctpr_pkg::COORD_WIDTH_DEF,
    parameter int ROTATION_STEPS = ctpr_pkg::ROTATION_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]       i_x_coord,
    input  logic signed [COORD_WIDTH-1:0]       i_y_coord,
    input  logic                                i_last_point,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [ctpr_pkg::RADIUS_W-1:0]       o_radius,
    output logic signed [ctpr_pkg::REL_W-1:0]   o_rel_angle,
    output logic                                o_last_out
);
    import ctpr_pkg::*;

    localparam int XW = COORD_WIDTH + 18;

    logic                  en;
    t_ctl                  ctl   [0:SQRT_STEPS];
    logic signed [XW-1:0]  cx    [0:SQRT_STEPS];
    logic signed [XW-1:0]  cy    [0:SQRT_STEPS];
    logic signed [Z_W-1:0] cz    [0:SQRT_STEPS];
    logic [SQ_OP_W-1:0]    op    [0:SQRT_STEPS];
    logic [REM_W-1:0]      rem   [0:SQRT_STEPS];
    logic [ROOT_W-1:0]     root  [0:SQRT_STEPS];

    assign o_in_ready = en;
    assign rem[0]     = '0;
    assign root[0]    = '0;

    ctpr_prep #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_in_valid),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_last_point (i_last_point),
        .o_ctl        (ctl[0]),
        .o_x          (cx[0]),
        .o_y          (cy[0]),
        .o_z          (cz[0]),
        .o_op         (op[0])
    );

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
        ctpr_cell #(
            .COORD_WIDTH    (COORD_WIDTH),
            .ROTATION_STEPS (ROTATION_STEPS),
            .STEP           (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[k]),
            .i_x     (cx[k]),
            .i_y     (cy[k]),
            .i_z     (cz[k]),
            .i_op    (op[k]),
            .i_rem   (rem[k]),
            .i_root  (root[k]),
            .o_ctl   (ctl[k+1]),
            .o_x     (cx[k+1]),
            .o_y     (cy[k+1]),
            .o_z     (cz[k+1]),
            .o_op    (op[k+1]),
            .o_rem   (rem[k+1]),
            .o_root  (root[k+1])
        );
    end

    ctpr_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl[SQRT_STEPS]),
        .i_z         (cz[SQRT_STEPS]),
        .i_root      (root[SQRT_STEPS]),
        .i_out_ready (i_out_ready),
        .o_en        (en),
        .o_out_valid (o_out_valid),
        .o_radius    (o_radius),
        .o_rel_angle (o_rel_angle),
        .o_last_out  (o_last_out)
    );

endmodule
